>>> design/packed_list_store_defines.svh
// Assertion macros for the packed list store.
// Included by the top level; no other dependencies.
`ifndef PACKED_LIST_STORE_DEFINES_SVH
`define PACKED_LIST_STORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PLST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define PLST_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`else
`define PLST_ASSERT(label, clk, rst, prop, msg)
`define PLST_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

>>> design/plst_pkg.sv
// Shared types, codes and default sizes of the packed list store.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package plst_pkg;

   localparam int NUM_IDS_DEF      = 1024;
   localparam int STORE_DEPTH_DEF  = 65536;
   localparam int MAX_LIST_LEN_DEF = 64;

   // Request modes.
   localparam logic [1:0] MODE_CLEAR      = 2'd0;
   localparam logic [1:0] MODE_APPEND_ID  = 2'd1;
   localparam logic [1:0] MODE_APPEND_NEW = 2'd2;
   localparam logic [1:0] MODE_READ       = 2'd3;

   // Response status codes.
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SET    = 3'd1;
   localparam logic [2:0] ST_RANGE  = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_NOLIST = 3'd4;
   localparam logic [2:0] ST_LONG   = 3'd5;

   localparam logic [6:0] RUN_LEN_SAT = 7'd127;

   typedef struct packed {
      logic [1:0]          mode;
      logic [10:0]         id_count;
      logic [9:0]          list_id;
      logic signed [31:0]  value;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [9:0]          result_id;
      logic signed [31:0]  item;
      logic [5:0]          position;
      logic                final_res;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/plst_req_if.sv
// Request channel of the packed list store: valid, ready and one request.
// Depends on plst_pkg.
`default_nettype none

interface plst_req_if;
   import plst_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/plst_rsp_if.sv
// Response channel of the packed list store: valid, ready and one response.
// Depends on plst_pkg.
`default_nettype none

interface plst_rsp_if;
   import plst_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/packed_list_store.sv
// Packed list store top level: start table memory, packed store memory, control.
// Depends on plst_pkg, plst_req_if, plst_rsp_if and packed_list_store_defines.svh.
//
//   Channel   Direction  Handshake     Transaction
//   req_ch    in         valid/ready   clear, append item or read request
//   rsp_ch    out        valid/ready   append status or one item of a read list
//
// An append item continuing a run is stored when accepted, a first item of a run
// to a given ID waits for a start table lookup, and a closing item of a good run
// adds a commit step to write the count word and table entry. A read passes a
// table read and a count read to its first item, then gives one item per cycle
// unless the response stalls, set by the single read port of the packed store.
// A clear sweeps min(id_count, NUM_IDS) start table entries, one per cycle.
// Reset needs no sweep: IDs are only usable after allocation, which invalidates
// the entry. A stalled response holds the block once its register is full.
`default_nettype none
`include "packed_list_store_defines.svh"

module packed_list_store #(
   parameter int NUM_IDS      = plst_pkg::NUM_IDS_DEF,
   parameter int STORE_DEPTH  = plst_pkg::STORE_DEPTH_DEF,
   parameter int MAX_LIST_LEN = plst_pkg::MAX_LIST_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   plst_req_if.sink     req_ch,
   plst_rsp_if.source   rsp_ch
);
   import plst_pkg::*;

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int FW = $clog2(STORE_DEPTH + 1);
   localparam int EW = FW + 1;
   localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
   localparam int CW = $clog2(NUM_IDS + 1);
   localparam int TW = AW + 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CLEAR   = 3'd1;
   localparam logic [2:0] S_CHECK   = 3'd2;
   localparam logic [2:0] S_COMMIT  = 3'd3;
   localparam logic [2:0] S_RLOOK   = 3'd4;
   localparam logic [2:0] S_RCOUNT  = 3'd5;
   localparam logic [2:0] S_RSTREAM = 3'd6;

   // Control registers.
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] ids_ff, ids_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] run_start_ff, run_start_in;
   logic [6:0]    run_len_ff, run_len_in;
   logic [9:0]    run_id_ff, run_id_in;
   logic [IW-1:0] run_idx_ff, run_idx_in;
   logic [2:0]    run_err_ff, run_err_in;
   logic          rsp_valid_ff;

   // Working registers.
   logic [CW-1:0] clr_ff, clr_in;
   logic [31:0]   hold_value_ff, hold_value_in;
   logic          hold_last_ff, hold_last_in;
   logic [9:0]    rd_id_ff, rd_id_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [5:0]    pos_ff, pos_in;
   rsp_type       rsp_data_ff;

   // Memories and their ports.
   logic [TW-1:0] tbl_mem [NUM_IDS];
   logic [TW-1:0] tbl_q_ff;
   logic          tbl_we, tbl_re;
   logic [IW-1:0] tbl_waddr, tbl_raddr;
   logic [TW-1:0] tbl_wdata;

   logic [31:0]   store_mem [STORE_DEPTH];
   logic [31:0]   store_q_ff;
   logic          st_we, st_re;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [31:0]   st_wdata;
   logic [5:0]    rd_pos;

   logic          rsp_free, req_ready, req_fire, run_open;
   logic          rsp_load;
   rsp_type       rsp_next;
   req_type       req;

   // Run opening and item processing.
   logic [2:0]    open_err;
   logic [9:0]    open_id;
   logic [IW-1:0] open_idx;
   logic          open_alloc, open_check;

   logic [2:0]    p_err;
   logic [FW-1:0] p_start;
   logic [31:0]   p_value;
   logic          p_last;
   logic [9:0]    p_id;
   logic [2:0]    pr_err;
   logic          pr_we;
   logic [AW-1:0] pr_addr;
   logic [6:0]    pr_len;
   logic [EW-1:0] a_end;
   logic          do_item;

   assign req       = req_ch.payload;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire  = req_ch.valid && req_ready;
   assign run_open  = (run_len_ff != 7'd0);

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_comb begin
      open_err   = ST_OK;
      open_id    = req.list_id;
      open_idx   = IW'(req.list_id);
      open_alloc = 1'b0;
      open_check = 1'b0;
      if (req.mode == MODE_APPEND_ID) begin
         if (32'(req.list_id) < 32'(ids_ff)) begin
            open_check = 1'b1;
         end else begin
            open_err = ST_RANGE;
         end
      end else if (32'(ids_ff) >= 32'(NUM_IDS)) begin
         open_err = ST_RANGE;
         open_id  = '0;
         open_idx = '0;
      end else begin
         open_id    = 10'(ids_ff);
         open_idx   = IW'(ids_ff);
         open_alloc = 1'b1;
      end
   end

   // Operands of the item step: from the table lookup or from the request.
   always_comb begin
      if (state_ff == S_CHECK) begin
         p_err   = tbl_q_ff[TW-1] ? ST_SET : ST_OK;
         p_start = run_start_ff;
         p_value = hold_value_ff;
         p_last  = hold_last_ff;
         p_id    = run_id_ff;
      end else begin
         p_err   = run_open ? run_err_ff : open_err;
         p_start = run_open ? run_start_ff : fill_ff;
         p_value = req.value;
         p_last  = req.last;
         p_id    = run_open ? run_id_ff : open_id;
      end
   end

   always_comb begin
      a_end   = EW'(p_start) + EW'(1) + EW'(run_len_ff);
      pr_addr = a_end[AW-1:0];
      pr_err  = p_err;
      pr_we   = 1'b0;
      if (p_err == ST_OK) begin
         if (32'(run_len_ff) >= 32'(MAX_LIST_LEN)) begin
            pr_err = ST_LONG;
         end else if (32'(a_end) >= 32'(STORE_DEPTH)) begin
            pr_err = ST_FULL;
         end else begin
            pr_we = 1'b1;
         end
      end
      pr_len = (run_len_ff < RUN_LEN_SAT) ? run_len_ff + 7'd1 : run_len_ff;
   end

   always_comb begin
      state_in      = state_ff;
      ids_in        = ids_ff;
      fill_in       = fill_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      run_id_in     = run_id_ff;
      run_idx_in    = run_idx_ff;
      run_err_in    = run_err_ff;
      clr_in        = clr_ff;
      hold_value_in = hold_value_ff;
      hold_last_in  = hold_last_ff;
      rd_id_in      = rd_id_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = run_idx_ff;
      tbl_wdata     = '0;
      tbl_re        = 1'b0;
      tbl_raddr     = IW'(req.list_id);
      st_we         = 1'b0;
      st_waddr      = pr_addr;
      st_wdata      = p_value;
      st_re         = 1'b0;
      rd_pos        = '0;
      rsp_load      = 1'b0;
      rsp_next      = '0;
      do_item       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req.mode)
                  MODE_CLEAR: begin
                     if (32'(req.id_count) > 32'(NUM_IDS)) begin
                        ids_in = CW'(NUM_IDS);
                     end else begin
                        ids_in = CW'(req.id_count);
                     end
                     fill_in      = '0;
                     run_start_in = '0;
                     run_len_in   = '0;
                     run_id_in    = '0;
                     run_idx_in   = '0;
                     run_err_in   = ST_OK;
                     clr_in       = '0;
                     if (req.id_count != 11'd0) begin
                        state_in = S_CLEAR;
                     end
                  end
                  MODE_READ: begin
                     if (32'(req.list_id) >= 32'(ids_ff)) begin
                        rsp_load           = 1'b1;
                        rsp_next.status    = ST_RANGE;
                        rsp_next.result_id = req.list_id;
                        rsp_next.final_res = 1'b1;
                     end else begin
                        tbl_re   = 1'b1;
                        rd_id_in = req.list_id;
                        state_in = S_RLOOK;
                     end
                  end
                  MODE_APPEND_ID, MODE_APPEND_NEW: begin
                     if (run_open) begin
                        do_item = 1'b1;
                     end else begin
                        run_start_in = fill_ff;
                        run_id_in    = open_id;
                        run_idx_in   = open_idx;
                        if (open_alloc) begin
                           // A newly numbered ID starts unset.
                           tbl_we    = 1'b1;
                           tbl_waddr = open_idx;
                           ids_in    = ids_ff + CW'(1);
                        end
                        if (open_check) begin
                           tbl_re        = 1'b1;
                           tbl_raddr     = open_idx;
                           hold_value_in = req.value;
                           hold_last_in  = req.last;
                           state_in      = S_CHECK;
                        end else begin
                           do_item = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = IW'(clr_ff);
            clr_in    = clr_ff + CW'(1);
            if (clr_ff + CW'(1) == ids_ff) begin
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            do_item  = 1'b1;
            state_in = S_IDLE;
         end
         S_COMMIT: begin
            st_we              = 1'b1;
            st_waddr           = run_start_ff[AW-1:0];
            st_wdata           = 32'(run_len_ff);
            tbl_we             = 1'b1;
            tbl_waddr          = run_idx_ff;
            tbl_wdata          = {1'b1, run_start_ff[AW-1:0]};
            fill_in            = FW'(EW'(run_start_ff) + EW'(1) + EW'(run_len_ff));
            run_len_in         = '0;
            run_err_in         = ST_OK;
            rsp_load           = 1'b1;
            rsp_next.status    = ST_OK;
            rsp_next.result_id = run_id_ff;
            rsp_next.final_res = 1'b1;
            state_in           = S_IDLE;
         end
         S_RLOOK: begin
            if (!tbl_q_ff[TW-1]) begin
               rsp_load           = 1'b1;
               rsp_next.status    = ST_NOLIST;
               rsp_next.result_id = rd_id_ff;
               rsp_next.final_res = 1'b1;
               state_in           = S_IDLE;
            end else begin
               st_re    = 1'b1;
               ptr_in   = tbl_q_ff[AW-1:0];
               state_in = S_RCOUNT;
            end
         end
         S_RCOUNT: begin
            if (store_q_ff == 32'd0) begin
               cnt_in = 7'd1;
            end else if (store_q_ff > 32'(MAX_LIST_LEN)) begin
               cnt_in = 7'(MAX_LIST_LEN);
            end else begin
               cnt_in = store_q_ff[6:0];
            end
            st_re    = 1'b1;
            pos_in   = '0;
            state_in = S_RSTREAM;
         end
         S_RSTREAM: begin
            // The read data register holds its item until the response slot frees.
            if (rsp_free) begin
               rsp_load           = 1'b1;
               rsp_next.status    = ST_OK;
               rsp_next.result_id = rd_id_ff;
               rsp_next.item      = store_q_ff;
               rsp_next.position  = pos_ff;
               rsp_next.final_res = (7'(pos_ff) + 7'd1 == cnt_ff);
               if (7'(pos_ff) + 7'd1 == cnt_ff) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in = pos_ff + 6'd1;
                  rd_pos = pos_ff + 6'd1;
                  st_re  = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_item) begin
         if (pr_we) begin
            st_we = 1'b1;
         end
         if (p_last) begin
            if (pr_err == ST_OK) begin
               run_len_in = pr_len;
               run_err_in = ST_OK;
               state_in   = S_COMMIT;
            end else begin
               run_len_in         = '0;
               run_err_in         = ST_OK;
               rsp_load           = 1'b1;
               rsp_next.status    = pr_err;
               rsp_next.result_id = p_id;
               rsp_next.final_res = 1'b1;
            end
         end else begin
            run_len_in = pr_len;
            run_err_in = pr_err;
         end
      end
   end

   assign st_raddr = (state_ff == S_RLOOK) ? tbl_q_ff[AW-1:0]
                                           : AW'(EW'(ptr_ff) + EW'(1) + EW'(rd_pos));

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_q_ff <= tbl_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         store_q_ff <= store_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ids_ff       <= '0;
         fill_ff      <= '0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         run_id_ff    <= '0;
         run_idx_ff   <= '0;
         run_err_ff   <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ids_ff       <= ids_in;
         fill_ff      <= fill_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         run_id_ff    <= run_id_in;
         run_idx_ff   <= run_idx_in;
         run_err_ff   <= run_err_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      clr_ff        <= clr_in;
      hold_value_ff <= hold_value_in;
      hold_last_ff  <= hold_last_in;
      rd_id_ff      <= rd_id_in;
      ptr_ff        <= ptr_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   `PLST_ASSERT(a_fill_bound, clock, reset, 32'(fill_ff) <= 32'(STORE_DEPTH), "fill level beyond store depth")
   `PLST_ASSERT(a_clear_bound, clock, reset, (state_ff == S_CLEAR) |-> (clr_ff < ids_ff), "clear sweep past the ID count")
   `PLST_ASSERT(a_stream_count, clock, reset, (state_ff == S_RSTREAM) |-> ((cnt_ff != 7'd0) && (32'(cnt_ff) <= 32'(MAX_LIST_LEN)) && (7'(pos_ff) < cnt_ff)), "read position outside the list")
   `PLST_ASSERT_NEXT(a_commit_rsp, clock, reset, state_ff == S_COMMIT, rsp_valid_ff && (rsp_data_ff.status == ST_OK), "committed run gave no good response")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for packed_list_store: random and directed append, read and
// clear traffic with random stalls on both channels. Depends on plst_pkg and the channels.
module tb_top;
   import plst_pkg::*;

   logic clock = 1'b0;
   logic reset;

   plst_req_if req_ch ();
   plst_rsp_if rsp_ch ();

   packed_list_store u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // Predicted contents of the block.
   bit              lst_valid [NUM_IDS_DEF];
   bit [16:0]       lst_start [NUM_IDS_DEF];
   bit [31:0]       store_mem [STORE_DEPTH_DEF];
   int unsigned     fill_lvl = 0;
   int unsigned     ids_used = 0;
   int unsigned     run_base = 0;
   int unsigned     run_len  = 0;
   int unsigned     run_tag  = 0;
   logic [2:0]      run_err  = ST_OK;

   req_type         req_backlog [$];
   rsp_type         due_rsp_q [$];
   int              mismatch_cnt = 0;
   int              req_accepted = 0;
   bit              req_taken = 1'b0;
   bit              gen_done = 1'b0;
   int              quiet_start = 32'h7fff_ffff;

   // Generator view of which IDs hold a list.
   int              gen_ids = 0;
   bit              gen_set [NUM_IDS_DEF];
   int              gen_fill = 0;
   int              gen_items = 0;

   int              req_hold = 0;
   int              rsp_hold = 0;
   int              req_cyc = 0;
   int              rsp_cyc = 0;
   bit              req_calm = 1'b0;
   bit              rsp_calm = 1'b0;

   function automatic void predict_responses(req_type r);
      rsp_type     o;
      int unsigned ptr;
      int unsigned cnt;
      int unsigned a;
      o = '0;
      o.result_id = r.list_id;
      o.final_res = 1'b1;
      if (r.mode == MODE_CLEAR) begin
         lst_valid = '{default: 1'b0};
         fill_lvl = 0;
         ids_used = (r.id_count > NUM_IDS_DEF) ? NUM_IDS_DEF : r.id_count;
         run_len = 0;
         run_err = ST_OK;
         run_base = 0;
         run_tag = 0;
      end else if (r.mode == MODE_READ) begin
         if (r.list_id >= ids_used) begin
            o.status = ST_RANGE;
            due_rsp_q.push_back(o);
         end else if (!lst_valid[r.list_id]) begin
            o.status = ST_NOLIST;
            due_rsp_q.push_back(o);
         end else begin
            ptr = lst_start[r.list_id];
            cnt = (ptr < STORE_DEPTH_DEF) ? store_mem[ptr] : 1;
            if (cnt < 1) cnt = 1;
            if (cnt > MAX_LIST_LEN_DEF) cnt = MAX_LIST_LEN_DEF;
            for (int unsigned k = 0; k < cnt; k++) begin
               a = ptr + 1 + k;
               o.status = ST_OK;
               o.item = (a < STORE_DEPTH_DEF) ? store_mem[a] : 32'd0;
               o.position = 6'(k);
               o.final_res = (k + 1 == cnt);
               due_rsp_q.push_back(o);
            end
         end
      end else begin
         if (run_len == 0) begin
            run_err = ST_OK;
            run_base = fill_lvl;
            if (r.mode == MODE_APPEND_ID) begin
               run_tag = r.list_id;
               if (r.list_id >= ids_used) run_err = ST_RANGE;
               else if (lst_valid[r.list_id]) run_err = ST_SET;
            end else if (ids_used >= NUM_IDS_DEF) begin
               run_tag = 0;
               run_err = ST_RANGE;
            end else begin
               run_tag = ids_used;
               lst_valid[run_tag] = 1'b0;
               ids_used++;
            end
         end
         if (run_err == ST_OK) begin
            if (run_len >= MAX_LIST_LEN_DEF) begin
               run_err = ST_LONG;
            end else begin
               a = run_base + 1 + run_len;
               if (run_base >= STORE_DEPTH_DEF || a >= STORE_DEPTH_DEF) run_err = ST_FULL;
               else store_mem[a] = r.value;
            end
         end
         if (run_len < RUN_LEN_SAT) run_len++;
         if (r.last) begin
            if (run_err == ST_OK) begin
               store_mem[run_base] = run_len;
               lst_start[run_tag] = 17'(run_base);
               lst_valid[run_tag] = 1'b1;
               fill_lvl = run_base + 1 + run_len;
            end
            o.status = run_err;
            o.result_id = 10'(run_tag);
            due_rsp_q.push_back(o);
            run_len = 0;
            run_err = ST_OK;
         end
      end
   endfunction

   task automatic push_req(logic [1:0] mode, int cnt, int lid, logic [31:0] val, int last);
      req_type r;
      r.mode = mode;
      r.id_count = 11'(cnt);
      r.list_id = 10'(lid);
      r.value = val;
      r.last = 1'(last);
      req_backlog.push_back(r);
      gen_items++;
   endtask

   task automatic gen_read(int id);
      push_req(MODE_READ, $urandom_range(0, 1024), id, $urandom, $urandom_range(0, 1));
   endtask

   task automatic gen_clear(int n);
      push_req(MODE_CLEAR, n, $urandom_range(0, 1023), $urandom, $urandom_range(0, 1));
      gen_ids = (n > NUM_IDS_DEF) ? NUM_IDS_DEF : n;
      gen_set = '{default: 1'b0};
      gen_fill = 0;
   endtask

   // Returns an ID below the current count that is set (or unset), else any ID.
   function automatic int pick_id(bit want_set);
      int s;
      if (gen_ids == 0) return $urandom_range(0, 1023);
      s = $urandom_range(0, gen_ids - 1);
      for (int i = 0; i < gen_ids; i++)
         if (gen_set[(s + i) % gen_ids] == want_set) return (s + i) % gen_ids;
      return $urandom_range(0, 1023);
   endfunction

   function automatic int pick_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 85) return $urandom_range(1, 8);
      if (p < 97) return $urandom_range(9, MAX_LIST_LEN_DEF);
      return $urandom_range(MAX_LIST_LEN_DEF + 1, MAX_LIST_LEN_DEF + 6);
   endfunction

   // One append run. Continuation items carry random modes and IDs, which the block
   // must ignore. With mix set, reads may be slipped in while the run is open; with
   // cut set the run is left open for a following clear to drop.
   task automatic gen_run(logic [1:0] mode, int id, int len, logic [31:0] first_val,
                          bit mix, bit cut);
      int tag;
      bit ok;
      ok = (len <= MAX_LIST_LEN_DEF) && (gen_fill + len < STORE_DEPTH_DEF);
      tag = id;
      if (mode == MODE_APPEND_ID) begin
         ok = ok && (id < gen_ids) && !gen_set[id];
      end else if (gen_ids >= NUM_IDS_DEF) begin
         ok = 1'b0;
      end else begin
         tag = gen_ids;
         gen_set[tag] = 1'b0;
         gen_ids++;
      end
      for (int k = 0; k < len; k++) begin
         push_req((k == 0) ? mode :
                  (($urandom_range(0, 1) != 0) ? MODE_APPEND_ID : MODE_APPEND_NEW),
                  $urandom_range(0, 1024), (k == 0) ? id : $urandom_range(0, 1023),
                  (k == 0) ? first_val : $urandom, !cut && (k == len - 1));
         if (mix && k < len - 1 && $urandom_range(0, 7) == 0)
            gen_read(($urandom_range(0, 1) != 0) ? pick_id(1'b1) : $urandom_range(0, 1023));
      end
      if (ok && !cut) begin
         gen_set[tag] = 1'b1;
         gen_fill += len + 1;
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      int rnd_stop;
      int pick;

      // Directed opening: empty table, extremes of the item value, full ID table,
      // a set ID, out-of-range IDs, continuation items with stray modes and IDs.
      gen_read(0);
      gen_run(MODE_APPEND_NEW, 0, 1, 32'h7fff_ffff, 1'b0, 1'b0);
      gen_read(0);
      gen_clear(NUM_IDS_DEF);
      gen_run(MODE_APPEND_NEW, 0, 1, 32'h8000_0000, 1'b0, 1'b0);
      gen_read(NUM_IDS_DEF - 1);
      gen_run(MODE_APPEND_ID, NUM_IDS_DEF - 1, 3, 32'hffff_ffff, 1'b0, 1'b0);
      gen_read(NUM_IDS_DEF - 1);
      gen_run(MODE_APPEND_ID, NUM_IDS_DEF - 1, 1, 32'h0, 1'b0, 1'b0);
      gen_clear(5);
      gen_run(MODE_APPEND_ID, 5, 1, $urandom, 1'b0, 1'b0);
      gen_read(7);
      gen_run(MODE_APPEND_NEW, 0, 3, 32'h0, 1'b1, 1'b0);
      gen_read(5);
      gen_run(MODE_APPEND_ID, 0, 2, 32'h8000_0000, 1'b0, 1'b0);
      gen_read(0);
      gen_read(1);

      // Random traffic, mostly well-formed runs and reads of lists that exist.
      gen_clear($urandom_range(8, 40));
      rnd_stop = 400;
      while (gen_items < rnd_stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            gen_clear(($urandom_range(0, 9) == 0) ? NUM_IDS_DEF : $urandom_range(0, 40));
         end else if (pick < 30) begin
            gen_run(MODE_APPEND_NEW, $urandom_range(0, 1023), pick_len(), $urandom,
                    1'b1, 1'b0);
         end else if (pick < 50) begin
            gen_run(MODE_APPEND_ID, pick_id(1'b0), pick_len(), $urandom, 1'b1, 1'b0);
         end else if (pick < 80) begin
            gen_read(pick_id(1'b1));
         end else if (pick < 88) begin
            gen_run(MODE_APPEND_ID,
                    ($urandom_range(0, 1) != 0) ? pick_id(1'b1) : $urandom_range(0, 1023),
                    $urandom_range(1, 3), $urandom, 1'b0, 1'b0);
         end else if (pick < 92) begin
            gen_read($urandom_range(0, 1023));
         end else if (pick < 95) begin
            gen_run(($urandom_range(0, 1) != 0) ? MODE_APPEND_ID : MODE_APPEND_NEW,
                    pick_id(1'b0), $urandom_range(1, 5), $urandom, 1'b1, 1'b1);
            gen_clear($urandom_range(1, 40));
         end else begin
            gen_read(pick_id(1'b0));
         end
      end

      // Closing stretch without stalls: an overlong run, short runs on new and set
      // IDs, and reads at the edges of the ID range.
      quiet_start = gen_items;
      gen_clear(0);
      gen_run(MODE_APPEND_NEW, 0, MAX_LIST_LEN_DEF + 2, $urandom, 1'b0, 1'b0);
      gen_run(MODE_APPEND_NEW, 0, 1, $urandom, 1'b0, 1'b0);
      gen_run(MODE_APPEND_NEW, 0, 2, $urandom, 1'b0, 1'b0);
      gen_run(MODE_APPEND_ID, 1, 1, $urandom, 1'b0, 1'b0);
      gen_read(0);
      gen_read(1);
      gen_read(gen_ids - 2);
      gen_read(gen_ids - 1);
      gen_read(gen_ids);
      gen_read(gen_ids - 5);
      gen_done = 1'b1;
   end

   // Request driver: new transactions are presented at the falling edge.
   always @(negedge clock) begin
      req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         req_cyc++;
         if (req_cyc % 256 == 0) req_calm = ($urandom_range(0, 3) == 0);
         if (!req_ch.valid || req_taken) begin
            if (req_ch.valid && !req_calm && req_accepted < quiet_start &&
                $urandom_range(0, 4) == 0)
               req_hold = $urandom_range(1, 9);
            if (req_hold > 0) begin
               req_hold--;
               req_ch.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               req_ch.payload <= nxt;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready with random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_cyc++;
         if (rsp_cyc % 256 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!rsp_calm && req_accepted < quiet_start && $urandom_range(0, 5) == 0)
               rsp_hold = $urandom_range(1, 9);
         end
      end
   end

   task automatic report(string what, longint want, longint got);
      mismatch_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   // Monitor: predicts on each accepted request, checks each accepted response.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            predict_responses(req_ch.payload);
            req_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_rsp_q.size() == 0) begin
               mismatch_cnt++;
               $display("%0t: expected no transaction, got status %0d id %0d item %0d",
                        $time, rsp_ch.payload.status, rsp_ch.payload.result_id,
                        rsp_ch.payload.item);
            end else begin
               want = due_rsp_q.pop_front();
               if (rsp_ch.payload.status !== want.status)
                  report("status", want.status, rsp_ch.payload.status);
               if (rsp_ch.payload.result_id !== want.result_id)
                  report("result_id", want.result_id, rsp_ch.payload.result_id);
               if (rsp_ch.payload.item !== want.item)
                  report("item", want.item, rsp_ch.payload.item);
               if (rsp_ch.payload.position !== want.position)
                  report("position", want.position, rsp_ch.payload.position);
               if (rsp_ch.payload.final_res !== want.final_res)
                  report("final_res", want.final_res, rsp_ch.payload.final_res);
            end
         end
      end
   end

   initial begin
      wait (gen_done);
      while (!(req_backlog.size() == 0 && !req_ch.valid && due_rsp_q.size() == 0))
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end
endmodule
